// ===== rtl/blsr_pkg.sv =====
// ----------------------------------------------------------------------------
// blsr_pkg: shared types and constants of the brush line stamp rasterizer
// Field widths, command codes and the stamp result record passed from the
// line walker to the output register.
// ----------------------------------------------------------------------------
package blsr_pkg;

    // Default parameter values
    localparam int COORD_BITS_DEF = 12;
    localparam int MAX_BRUSH_DEF  = 50;

    // Fixed field widths
    localparam int IN_COORD_W = 12;
    localparam int BRUSH_W    = 6;
    localparam int COLOR_W    = 8;
    localparam int OUT_POS_W  = 13;

    // Stream widths
    localparam int IN_TDATA_W  = 64;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 2;

    // Command codes
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // One stamp result
    typedef struct packed {
        logic                 stamp_valid;
        logic [OUT_POS_W-1:0] stamp_left;
        logic [OUT_POS_W-1:0] stamp_top;
        logic [BRUSH_W-1:0]   stamp_size;
        logic [COLOR_W-1:0]   stamp_color;
        logic                 line_done;
        logic                 rejected;
    } stamp_t;

endpackage

// ===== rtl/brush_line_stamp_rasterizer.sv =====
// ----------------------------------------------------------------------------
// brush_line_stamp_rasterizer: line segment to square brush stamps
// An accepted input beat is registered and appears as its stamp beat in the next cycle.
// Throughput: one input beat per cycle while the output drains; the segment
// walker updates its registers in a single pass, and the output register frees
// each cycle it is drained or empty.
// Reset clears the segment state (no active segment) and the output valid.
// ----------------------------------------------------------------------------
module brush_line_stamp_rasterizer #(
    parameter int COORD_BITS = blsr_pkg::COORD_BITS_DEF,
    parameter int MAX_BRUSH  = blsr_pkg::MAX_BRUSH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // x_from[11:0], y_from[23:12], x_to[35:24], y_to[47:36],
    // brush_size[53:48], stroke_color[61:54], zero pad[63:62]
    input  logic [blsr_pkg::IN_TDATA_W-1:0]     s_tdata,
    // cmd[0]
    input  logic [blsr_pkg::IN_TUSER_W-1:0]     s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // stamp_left[12:0], stamp_top[25:13], stamp_size[31:26], stamp_color[39:32]
    output logic [blsr_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // stamp_valid[0], rejected[1]
    output logic [blsr_pkg::OUT_TUSER_W-1:0]    m_tuser,
    // line_done
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready
);
    import blsr_pkg::*;

    logic   step_en;
    stamp_t result;
    stamp_t out_reg;
    logic   m_valid_reg, m_valid_next;

    // Take a beat whenever the output register is empty or draining
    assign s_tready = !m_valid_reg || m_tready;
    assign step_en  = s_tvalid && s_tready;

    blsr_walk #(
        .COORD_BITS (COORD_BITS),
        .MAX_BRUSH  (MAX_BRUSH)
    ) u_walk (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (step_en),
        .cmd          (s_tuser[0]),
        .x_from       (s_tdata[11:0]),
        .y_from       (s_tdata[23:12]),
        .x_to         (s_tdata[35:24]),
        .y_to         (s_tdata[47:36]),
        .brush_size   (s_tdata[53:48]),
        .stroke_color (s_tdata[61:54]),
        .result       (result)
    );

    // Hold output valid until taken
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (step_en)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Load the stamp payload
    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_reg.stamp_color, out_reg.stamp_size,
                       out_reg.stamp_top, out_reg.stamp_left};
    assign m_tuser  = {out_reg.rejected, out_reg.stamp_valid};
    assign m_tlast  = out_reg.line_done;

    // Every accepted beat yields an output beat next cycle
    a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> m_tvalid)
        else $error("accepted beat produced no stamp");

    // A rejected start carries no stamp and closes the line
    a_reject_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (!m_tuser[0] && m_tlast))
        else $error("rejected beat malformed");

    // A beat without a stamp has a zero payload and marks done
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> ((m_tdata == '0) && m_tlast))
        else $error("empty beat carries payload");

    // A start with a zero brush is rejected
    a_zero_brush: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && (s_tuser[0] == CMD_START) && (s_tdata[53:48] == '0))
        |=> (m_tvalid && m_tuser[1]))
        else $error("zero brush not rejected");

endmodule

// ===== rtl/blsr_walk.sv =====
// ----------------------------------------------------------------------------
// blsr_walk: Bresenham segment state and single-pass step logic
// Holds the segment registers. A valid-brush start latches a segment and
// yields the end stamp; an active advance moves a pixel along the major axis.
// ----------------------------------------------------------------------------
module blsr_walk #(
    parameter int COORD_BITS = blsr_pkg::COORD_BITS_DEF,
    parameter int MAX_BRUSH  = blsr_pkg::MAX_BRUSH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               step_en,
    input  logic                               cmd,
    input  logic [blsr_pkg::IN_COORD_W-1:0]    x_from,
    input  logic [blsr_pkg::IN_COORD_W-1:0]    y_from,
    input  logic [blsr_pkg::IN_COORD_W-1:0]    x_to,
    input  logic [blsr_pkg::IN_COORD_W-1:0]    y_to,
    input  logic [blsr_pkg::BRUSH_W-1:0]       brush_size,
    input  logic [blsr_pkg::COLOR_W-1:0]       stroke_color,
    output blsr_pkg::stamp_t                   result
);
    import blsr_pkg::*;

    localparam int POS_W = COORD_BITS + 2;
    localparam int EW    = POS_W + 2;

    // Segment state
    logic signed [POS_W-1:0]      major_pos_reg, major_pos_next;
    logic signed [POS_W-1:0]      minor_pos_reg, minor_pos_next;
    logic signed [POS_W-1:0]      err_acc_reg, err_acc_next;
    logic [COORD_BITS-1:0]        steps_left_reg, steps_left_next;
    logic [COORD_BITS-1:0]        major_span_reg, major_span_next;
    logic [COORD_BITS-1:0]        minor_span_reg, minor_span_next;
    logic                         major_dir_reg, major_dir_next;
    logic                         minor_dir_reg, minor_dir_next;
    logic                         steep_reg, steep_next;
    logic [BRUSH_W-1:0]           brush_reg, brush_next;
    logic [COLOR_W-1:0]           color_reg, color_next;
    logic                         active_reg, active_next;

    // Start path terms
    logic [COORD_BITS-1:0]        xf, yf, xt, yt;
    logic signed [POS_W-1:0]      rad;
    logic signed [POS_W-1:0]      x1, y1, x2, y2;
    logic signed [POS_W-1:0]      dxd, dyd, dad, dbd;
    logic [COORD_BITS-1:0]        dx, dy;
    logic                         steep_new;
    logic                         brush_bad;

    // Advance path terms
    logic signed [POS_W-1:0]      major_step, minor_step;
    logic signed [EW-1:0]         err_sum, err_dbl, span_ext;
    logic                         err_over;

    // Output position conversion
    logic signed [31:0]           left_wide, top_wide;

    // Mask coordinates and offset by half the brush
    always_comb
    begin
        xf  = COORD_BITS'(x_from);
        yf  = COORD_BITS'(y_from);
        xt  = COORD_BITS'(x_to);
        yt  = COORD_BITS'(y_to);
        rad = POS_W'(brush_size >> 1);
        x1  = signed'(POS_W'(xf)) - rad;
        y1  = signed'(POS_W'(yf)) - rad;
        x2  = signed'(POS_W'(xt)) - rad;
        y2  = signed'(POS_W'(yt)) - rad;
        dxd = x2 - x1;
        dyd = y2 - y1;
        dx  = (dxd < 0) ? COORD_BITS'(-dxd) : COORD_BITS'(dxd);
        dy  = (dyd < 0) ? COORD_BITS'(-dyd) : COORD_BITS'(dyd);
        steep_new = (dy > dx);
        dad = steep_new ? dyd : dxd;
        dbd = steep_new ? dxd : dyd;
        brush_bad = (brush_size == '0) ||
                    ({1'b0, brush_size} >= (BRUSH_W + 1)'(MAX_BRUSH));
    end

    // Bresenham step on the current segment
    always_comb
    begin
        major_step = major_dir_reg ? major_pos_reg - POS_W'(1) : major_pos_reg + POS_W'(1);
        minor_step = minor_dir_reg ? minor_pos_reg - POS_W'(1) : minor_pos_reg + POS_W'(1);
        span_ext   = signed'(EW'(major_span_reg));
        err_sum    = EW'(err_acc_reg) + signed'(EW'(minor_span_reg));
        err_dbl    = err_sum <<< 1;
        err_over   = (err_dbl > span_ext);
    end

    // Next state and result
    always_comb
    begin
        major_pos_next  = major_pos_reg;
        minor_pos_next  = minor_pos_reg;
        err_acc_next    = err_acc_reg;
        steps_left_next = steps_left_reg;
        major_span_next = major_span_reg;
        minor_span_next = minor_span_reg;
        major_dir_next  = major_dir_reg;
        minor_dir_next  = minor_dir_reg;
        steep_next      = steep_reg;
        brush_next      = brush_reg;
        color_next      = color_reg;
        active_next     = active_reg;
        left_wide       = '0;
        top_wide        = '0;
        result          = '0;
        result.line_done = 1'b1;

        if (cmd == CMD_START)
        begin
            if (brush_bad)
            begin
                // drop any segment and flag the beat
                active_next     = 1'b0;
                result.rejected = 1'b1;
            end
            else
            begin
                steep_next      = steep_new;
                major_span_next = steep_new ? dy : dx;
                minor_span_next = steep_new ? dx : dy;
                major_dir_next  = !(dad > 0);
                minor_dir_next  = !(dbd > 0);
                major_pos_next  = steep_new ? y1 : x1;
                minor_pos_next  = steep_new ? x1 : y1;
                err_acc_next    = '0;
                steps_left_next = steep_new ? dy : dx;
                brush_next      = brush_size;
                color_next      = stroke_color;
                active_next     = (steps_left_next != '0);
                left_wide       = 32'(x2);
                top_wide        = 32'(y2);
                result.stamp_valid = 1'b1;
                result.stamp_left  = left_wide[OUT_POS_W-1:0];
                result.stamp_top   = top_wide[OUT_POS_W-1:0];
                result.stamp_size  = brush_size;
                result.stamp_color = stroke_color;
                result.line_done   = !active_next;
            end
        end
        else if (active_reg)
        begin
            // advance one pixel along the major axis
            major_pos_next  = major_step;
            minor_pos_next  = err_over ? minor_step : minor_pos_reg;
            err_acc_next    = err_over ? POS_W'(err_sum - span_ext) : POS_W'(err_sum);
            steps_left_next = steps_left_reg - COORD_BITS'(1);
            active_next     = (steps_left_next != '0);
            left_wide       = steep_reg ? 32'(minor_pos_next) : 32'(major_pos_next);
            top_wide        = steep_reg ? 32'(major_pos_next) : 32'(minor_pos_next);
            result.stamp_valid = 1'b1;
            result.stamp_left  = left_wide[OUT_POS_W-1:0];
            result.stamp_top   = top_wide[OUT_POS_W-1:0];
            result.stamp_size  = brush_reg;
            result.stamp_color = color_reg;
            result.line_done   = !active_next;
        end
    end

    // Update segment state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            major_pos_reg  <= '0;
            minor_pos_reg  <= '0;
            err_acc_reg    <= '0;
            steps_left_reg <= '0;
            major_span_reg <= '0;
            minor_span_reg <= '0;
            major_dir_reg  <= 1'b0;
            minor_dir_reg  <= 1'b0;
            steep_reg      <= 1'b0;
            brush_reg      <= '0;
            color_reg      <= '0;
            active_reg     <= 1'b0;
        end
        else if (step_en)
        begin
            major_pos_reg  <= major_pos_next;
            minor_pos_reg  <= minor_pos_next;
            err_acc_reg    <= err_acc_next;
            steps_left_reg <= steps_left_next;
            major_span_reg <= major_span_next;
            minor_span_reg <= minor_span_next;
            major_dir_reg  <= major_dir_next;
            minor_dir_reg  <= minor_dir_next;
            steep_reg      <= steep_next;
            brush_reg      <= brush_next;
            color_reg      <= color_next;
            active_reg     <= active_next;
        end
    end

    // An active segment always has steps remaining
    a_active_steps: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (steps_left_reg != '0))
        else $error("active segment with no steps left");

    // Error term never exceeds half the major span
    a_err_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> ((signed'(EW'(err_acc_reg)) <<< 1) <= span_ext))
        else $error("error accumulator out of bound");

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stream-level check of brush_line_stamp_rasterizer
// Drives start and advance beats with random gaps and random output stalls.
// Every accepted beat is run through a cycle-free line walker kept here, and
// each stamp beat from the block is checked, field by field, against it.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import blsr_pkg::*;

    localparam int N_RANDOM    = 950;
    localparam int DRAIN_EVERY = 200;
    localparam int CYCLE_LIMIT = 500000;
    localparam int COORD_MAX   = 4095;

    // One command beat as the stimulus sees it
    typedef struct {
        logic                  cmd;
        logic [IN_COORD_W-1:0] x_from;
        logic [IN_COORD_W-1:0] y_from;
        logic [IN_COORD_W-1:0] x_to;
        logic [IN_COORD_W-1:0] y_to;
        logic [BRUSH_W-1:0]    brush;
        logic [COLOR_W-1:0]    color;
        bit                    drain;
    } brush_cmd_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_tuser = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   m_tlast;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;

    brush_cmd_t pending_cmds[$];
    stamp_t     expected_stamps[$];
    brush_cmd_t on_bus;
    bit         beat_taken = 1'b0;
    bit         drain_next = 1'b0;

    int send_gap = 0;
    int send_burst = 0;
    int stall_left = 0;
    int stall_burst = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int n_starts = 0;
    int n_advances = 0;
    int n_results = 0;
    int n_stamps = 0;
    int n_rejects = 0;
    int n_line_ends = 0;
    int n_drains = 0;

    // Line walker state
    logic signed [13:0] major_pos;
    logic signed [13:0] minor_pos;
    logic signed [13:0] err_acc;
    logic [12:0]        steps_left;
    logic [12:0]        major_span;
    logic [12:0]        minor_span;
    logic               major_dec;
    logic               minor_dec;
    logic               steep;
    logic [BRUSH_W-1:0] brush_lat;
    logic [COLOR_W-1:0] color_lat;
    logic               seg_active;

    brush_line_stamp_rasterizer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int span_of(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Walk the segment by one beat and return the stamp it should produce
    function automatic stamp_t stamp_for_beat(brush_cmd_t c);
        stamp_t s;
        int     rad;
        int     x1, y1, x2, y2;
        int     a1, b1, a2, b2;
        int     acc;
        s = '0;
        if (c.cmd == CMD_START)
        begin
            // Reject a bad brush and drop any segment in flight
            if (c.brush == 0 || c.brush >= MAX_BRUSH_DEF)
            begin
                seg_active  = 1'b0;
                s.line_done = 1'b1;
                s.rejected  = 1'b1;
                return s;
            end
            rad = int'(c.brush) / 2;
            x1  = int'(c.x_from) - rad;
            y1  = int'(c.y_from) - rad;
            x2  = int'(c.x_to) - rad;
            y2  = int'(c.y_to) - rad;
            steep = span_of(y2, y1) > span_of(x2, x1);
            if (steep)
            begin
                a1 = y1; b1 = x1; a2 = y2; b2 = x2;
            end
            else
            begin
                a1 = x1; b1 = y1; a2 = x2; b2 = y2;
            end
            major_span = 13'(span_of(a2, a1));
            minor_span = 13'(span_of(b2, b1));
            major_dec  = !(a1 < a2);
            minor_dec  = !(b1 < b2);
            major_pos  = 14'(a1);
            minor_pos  = 14'(b1);
            err_acc    = '0;
            steps_left = major_span;
            brush_lat  = c.brush;
            color_lat  = c.color;
            seg_active = (steps_left != 0);
            s.stamp_valid = 1'b1;
            s.stamp_left  = 13'(x2);
            s.stamp_top   = 13'(y2);
            s.stamp_size  = c.brush;
            s.stamp_color = c.color;
            s.line_done   = !seg_active;
            return s;
        end
        if (!seg_active)
        begin
            s.line_done = 1'b1;
            return s;
        end
        // Step the major axis, then the minor axis when the error crosses half
        major_pos = 14'(int'(major_pos) + (major_dec ? -1 : 1));
        acc = int'(err_acc) + int'(minor_span);
        if (2 * acc > int'(major_span))
        begin
            minor_pos = 14'(int'(minor_pos) + (minor_dec ? -1 : 1));
            acc = acc - int'(major_span);
        end
        err_acc    = 14'(acc);
        steps_left = steps_left - 1'b1;
        if (steps_left == 0)
            seg_active = 1'b0;
        s.stamp_valid = 1'b1;
        s.stamp_left  = steep ? minor_pos[12:0] : major_pos[12:0];
        s.stamp_top   = steep ? major_pos[12:0] : minor_pos[12:0];
        s.stamp_size  = brush_lat;
        s.stamp_color = color_lat;
        s.line_done   = !seg_active;
        return s;
    endfunction

    // Mostly back to back or short idles, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(25, 70);
    endfunction

    function automatic int edge_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return $urandom_range(0, 24);
        if (r < 20)
            return $urandom_range(COORD_MAX - 24, COORD_MAX);
        return $urandom_range(0, COORD_MAX);
    endfunction

    function automatic int near_coord(int base, int spread);
        int v;
        v = base + $urandom_range(0, 2 * spread) - spread;
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return v;
    endfunction

    task automatic push_cmd(logic cmd, int xf, int yf, int xt, int yt, int brush, int color);
        brush_cmd_t c;
        c.cmd    = cmd;
        c.x_from = 12'(xf);
        c.y_from = 12'(yf);
        c.x_to   = 12'(xt);
        c.y_to   = 12'(yt);
        c.brush  = 6'(brush);
        c.color  = 8'(color);
        c.drain  = drain_next;
        drain_next = 1'b0;
        pending_cmds = {pending_cmds, c};
    endtask

    // Advance beats carry random payload that the block must ignore
    task automatic push_advance(int n);
        repeat (n)
            push_cmd(CMD_ADVANCE, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                     $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                     $urandom_range(0, 63), $urandom_range(0, 255));
    endtask

    task automatic push_directed();
        push_advance(1);
        push_cmd(CMD_START, 5, 6, 7, 8, 0, 33);
        push_cmd(CMD_START, 5, 6, 7, 8, MAX_BRUSH_DEF, 33);
        push_cmd(CMD_START, 5, 6, 7, 8, 63, 33);
        push_cmd(CMD_START, 0, 0, 0, 0, 1, 0);
        push_cmd(CMD_START, COORD_MAX, 0, 0, COORD_MAX, 49, 255);
        push_advance(2);
        // New start abandons the long diagonal
        push_cmd(CMD_START, 10, 10, 11, 13, 2, 'h5a);
        push_advance(4);
        push_cmd(CMD_START, 20, 5, 16, 3, 7, 'ha5);
        push_advance(4);
        push_cmd(CMD_START, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1, 255);
        push_cmd(CMD_START, 100, 200, 130, 190, 48, 17);
        push_advance(1);
        push_cmd(CMD_START, 100, 200, 130, 190, 0, 17);
        push_advance(1);
    endtask

    // Mostly well-formed strokes, some rejected starts and raw noise
    task automatic push_random(int target);
        int first, next_drain;
        int r, spread, xf, yf, xt, yt, span, steps, brush;
        first = pending_cmds.size();
        next_drain = DRAIN_EVERY;
        while (pending_cmds.size() - first < target)
        begin
            if (pending_cmds.size() - first >= next_drain)
            begin
                drain_next = 1'b1;
                next_drain += DRAIN_EVERY;
            end
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                push_cmd($urandom_range(0, 1), $urandom_range(0, COORD_MAX),
                         $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                         $urandom_range(0, COORD_MAX), $urandom_range(0, 63),
                         $urandom_range(0, 255));
            end
            else if (r < 14)
            begin
                brush = $urandom_range(0, 14);
                brush = (brush == 0) ? 0 : MAX_BRUSH_DEF - 1 + brush;
                push_cmd(CMD_START, edge_coord(), edge_coord(), edge_coord(), edge_coord(),
                         brush, $urandom_range(0, 255));
                push_advance($urandom_range(0, 2));
            end
            else
            begin
                xf = edge_coord();
                yf = edge_coord();
                r = $urandom_range(0, 99);
                spread = (r < 70) ? 8 : (r < 92) ? 60 : COORD_MAX;
                if ($urandom_range(0, 4) == 0)
                begin
                    xt = xf;
                    yt = yf;
                end
                else
                begin
                    xt = near_coord(xf, spread);
                    yt = near_coord(yf, spread);
                end
                span = span_of(xt, xf);
                if (span_of(yt, yf) > span)
                    span = span_of(yt, yf);
                r = $urandom_range(0, 99);
                brush = (r < 10) ? 1 : (r < 20) ? MAX_BRUSH_DEF - 1
                                                : $urandom_range(1, MAX_BRUSH_DEF - 1);
                r = $urandom_range(0, 99);
                if (span > 300)
                    steps = $urandom_range(0, 40);
                else if (r < 65)
                    steps = span;
                else if (r < 80)
                    steps = span + $urandom_range(1, 2);
                else
                    steps = $urandom_range(0, span);
                push_cmd(CMD_START, xf, yf, xt, yt, brush, $urandom_range(0, 255));
                push_advance(steps);
            end
        end
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Present command beats; hold off where a drain is requested
    always @(negedge clk)
    begin : drive_cmds
        brush_cmd_t c;
        if (rst_n)
        begin
            if (!s_tvalid || beat_taken)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_cmds.size() == 0 ||
                         (pending_cmds[0].drain && expected_stamps.size() != 0))
                begin
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    c = pending_cmds.pop_front();
                    if (c.drain)
                        n_drains++;
                    on_bus = c;
                    s_tdata  <= {2'b00, c.color, c.brush, c.y_to, c.x_to, c.y_from, c.x_from};
                    s_tuser  <= c.cmd;
                    s_tvalid <= 1'b1;
                    if (send_burst > 0)
                    begin
                        send_burst--;
                        send_gap = 0;
                    end
                    else
                    begin
                        send_gap = idle_len();
                        if ($urandom_range(0, 49) == 0)
                            send_burst = $urandom_range(40, 120);
                    end
                end
            end
            beat_taken = 1'b0;
        end
    end

    // Stall the output side at random
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (stall_burst > 0)
                    stall_burst--;
                else
                begin
                    stall_left = idle_len();
                    if ($urandom_range(0, 49) == 0)
                        stall_burst = $urandom_range(40, 120);
                end
            end
        end
    end

    // Check stamp beats, predict from accepted command beats, watch the clock
    always @(posedge clk)
    begin : watch_beats
        stamp_t want;
        stamp_t got;
        if (rst_n)
        begin
            cycle_count++;
            if (m_tvalid && m_tready)
            begin
                got.stamp_valid = m_tuser[0];
                got.rejected    = m_tuser[1];
                got.line_done   = m_tlast;
                got.stamp_left  = m_tdata[12:0];
                got.stamp_top   = m_tdata[25:13];
                got.stamp_size  = m_tdata[31:26];
                got.stamp_color = m_tdata[39:32];
                n_results++;
                n_stamps    += got.stamp_valid;
                n_rejects   += got.rejected;
                n_line_ends += (got.line_done && got.stamp_valid);
                if (expected_stamps.size() == 0)
                begin
                    $error("stamp beat with no command pending");
                    mismatches++;
                end
                else
                begin
                    want = expected_stamps.pop_front();
                    check_field("stamp_valid", want.stamp_valid, got.stamp_valid);
                    check_field("stamp_left", $signed(want.stamp_left), $signed(got.stamp_left));
                    check_field("stamp_top", $signed(want.stamp_top), $signed(got.stamp_top));
                    check_field("stamp_size", want.stamp_size, got.stamp_size);
                    check_field("stamp_color", want.stamp_color, got.stamp_color);
                    check_field("line_done", want.line_done, got.line_done);
                    check_field("rejected", want.rejected, got.rejected);
                end
            end
            if (s_tvalid && s_tready)
            begin
                want = stamp_for_beat(on_bus);
                expected_stamps = {expected_stamps, want};
                beat_taken = 1'b1;
                if (on_bus.cmd == CMD_START)
                    n_starts++;
                else
                    n_advances++;
            end
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        seg_active = 1'b0;
        steep      = 1'b0;
        major_pos  = '0;
        minor_pos  = '0;
        err_acc    = '0;
        steps_left = '0;
        major_span = '0;
        minor_span = '0;
        major_dec  = 1'b0;
        minor_dec  = 1'b0;
        brush_lat  = '0;
        color_lat  = '0;
        push_directed();
        // Let the directed beats drain before the random strokes start
        drain_next = 1'b1;
        push_random(N_RANDOM);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        while (pending_cmds.size() != 0 || s_tvalid || expected_stamps.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (expected_stamps.size() != 0)
        begin
            $error("%0d stamp beats never arrived", expected_stamps.size());
            mismatches++;
        end
        $display("Ran %0d starts and %0d advances in %0d cycles, %0d drain pauses.",
                 n_starts, n_advances, cycle_count, n_drains);
        $display("Checked %0d result beats: %0d stamps, %0d rejects, %0d segment ends.",
                 n_results, n_stamps, n_rejects, n_line_ends);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/blsr_pkg.sv
rtl/blsr_walk.sv
rtl/brush_line_stamp_rasterizer.sv
sim/testbench.sv
